>>> sv/smvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_pkg
// Shared types, codes and constants for the sparse matrix-vector multiply.
// ----------------------------------------------------------------------------
package smvm_pkg;

  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_COLS = 1024;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 11;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_MAC   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
  } smvm_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [1:0]              status;
  } smvm_out_t;

  // request handed from the front end to the accumulator engine
  typedef struct packed {
    logic                    vld;
    logic [1:0]              op;
    logic                    ok;
    logic signed [VAL_W-1:0] value;
  } smvm_issue_t;

endpackage

>>> sv/smvm_vec_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_vec_mem
// Dense vector store: one write, one registered read, or both per request.
// ----------------------------------------------------------------------------
module smvm_vec_mem import smvm_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    we,
  input  logic [COL_AW-1:0]       addr,
  input  logic signed [VAL_W-1:0] wdata,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [MAX_COLS];
  logic signed [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/smvm_acc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_acc_engine
// Accumulator memory with read, multiply, round-add-saturate and write-back
// stages, row forwarding, clearing sweep and the result register.
// ----------------------------------------------------------------------------
module smvm_acc_engine import smvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  smvm_issue_t             iss,
  input  logic [ROW_AW-1:0]       iss_row,
  input  logic signed [VAL_W-1:0] vec_rd,
  output logic                    issue_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output smvm_out_t               out_data
);

  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(MAX_ROWS - 1);

  logic signed [ACC_W-1:0] acc_mem [MAX_ROWS];
  logic signed [ACC_W-1:0] acc_rd_r;

  // stage 1: memory data arrives, multiply
  logic                    s1_vld_r;
  logic [1:0]              s1_op_r;
  logic                    s1_ok_r;
  logic [ROW_AW-1:0]       s1_row_r;
  logic signed [VAL_W-1:0] s1_val_r;

  // stage 2: round, add, saturate, write back
  logic                    s2_vld_r;
  logic [1:0]              s2_op_r;
  logic                    s2_ok_r;
  logic [ROW_AW-1:0]       s2_row_r;
  logic signed [63:0]      s2_prod_r;
  logic signed [ACC_W-1:0] s2_acc_r;

  // last write-back, covers the read that raced it
  logic                    wb_vld_r;
  logic [ROW_AW-1:0]       wb_row_r;
  logic signed [ACC_W-1:0] wb_val_r;

  logic                    out_vld_r;
  smvm_out_t               out_r;

  logic                    sweep_r;
  logic [ROW_AW-1:0]       sweep_cnt_r;

  logic                    advance;
  logic signed [63:0]      prod_c;
  logic signed [ACC_W-1:0] term_c;
  logic signed [ACC_W:0]   sum_c;
  logic signed [ACC_W-1:0] new_acc_c;
  logic                    sat_c;
  logic                    s2_wr;
  logic signed [ACC_W-1:0] acc_fwd_c;
  smvm_out_t               res_c;
  logic                    wr_en;
  logic [ROW_AW-1:0]       wr_addr;
  logic signed [ACC_W-1:0] wr_data;
  logic                    s2_clear;

  assign advance  = !out_vld_r || out_ready;
  assign s2_clear = s2_vld_r && (s2_op_r == OP_CLEAR);

  // hold off new requests while the result is stalled, a clear is in flight or sweeping
  assign issue_ready = advance && !sweep_r
                       && !(s1_vld_r && (s1_op_r == OP_CLEAR)) && !s2_clear;

  assign prod_c = s1_val_r * vec_rd;

  always_comb begin
    term_c = ACC_W'((s2_prod_r + 64'sh8000) >>> 16);
    sum_c  = (ACC_W+1)'(s2_acc_r) + (ACC_W+1)'(term_c);
    sat_c  = (sum_c[ACC_W] != sum_c[ACC_W-1]);
    if (sat_c) begin
      new_acc_c = sum_c[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      new_acc_c = sum_c[ACC_W-1:0];
    end
  end

  assign s2_wr = s2_vld_r && (s2_op_r == OP_MAC) && s2_ok_r;

  always_comb begin
    if (s2_wr && (s2_row_r == s1_row_r)) begin
      acc_fwd_c = new_acc_c;
    end else if (wb_vld_r && (wb_row_r == s1_row_r)) begin
      acc_fwd_c = wb_val_r;
    end else begin
      acc_fwd_c = acc_rd_r;
    end
  end

  always_comb begin
    res_c.sum    = '0;
    res_c.status = ST_OK;
    if (!s2_ok_r) begin
      res_c.status = ST_RANGE;
    end else if ((s2_op_r == OP_MAC) && sat_c) begin
      res_c.status = ST_SAT;
    end else if (s2_op_r == OP_READ) begin
      res_c.sum = s2_acc_r;
    end
  end

  always_comb begin
    if (sweep_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = advance && s2_wr;
      wr_addr = s2_row_r;
      wr_data = new_acc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (iss.vld) begin
      acc_rd_r <= acc_mem[iss_row];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r   <= iss.op;
      s1_ok_r   <= iss.ok;
      s1_row_r  <= iss_row;
      s1_val_r  <= iss.value;
      s2_op_r   <= s1_op_r;
      s2_ok_r   <= s1_ok_r;
      s2_row_r  <= s1_row_r;
      s2_prod_r <= prod_c;
      s2_acc_r  <= acc_fwd_c;
      out_r     <= res_c;
      if (s2_wr) begin
        wb_row_r <= s2_row_r;
        wb_val_r <= new_acc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      wb_vld_r    <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else begin
      if (advance) begin
        s1_vld_r  <= iss.vld;
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
        if (s2_wr) begin
          wb_vld_r <= 1'b1;
        end
      end
      if (sweep_r) begin
        wb_vld_r <= 1'b0;
        if (sweep_cnt_r == ROW_LAST) begin
          sweep_r <= 1'b0;
        end else begin
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
        end
      end else if (advance && s2_clear) begin
        sweep_r     <= 1'b1;
        sweep_cnt_r <= '0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> sv/sparse_matrix_vector_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// Column-streamed sparse matrix times dense vector, Q16.16, with 48-bit
// saturating row accumulators.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_ready is high: vector loads,
// nonzero multiply-accumulates (repeated rows included, through forwarding
// around the accumulator memory), and accumulator reads. Each request passes
// through stage 1, stage 2 and the result register; a stalled result port holds
// the pipeline. A clear zeroes the accumulator memory one row a cycle: after
// the clear request is taken, and after reset, in_ready stays low until the
// sweep ends. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply import smvm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smvm_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output smvm_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CNT_W-1:0]        row_count_r;
  logic [CNT_W-1:0]        col_count_r;
  logic                    cfg_wr;
  logic                    accept;
  logic                    row_ok;
  logic                    col_ok;
  logic                    item_ok;
  logic                    issue_ready;
  logic signed [VAL_W-1:0] vec_rd;
  smvm_issue_t             iss;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_RESET;
      col_count_r <= CNT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: row_count_r <= pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = APB_DW'(row_count_r);
      REG_COL_COUNT: prdata = APB_DW'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  assign row_ok = ((CNT_W)'(in_data.row_index) < row_count_r)
                  && (32'(in_data.row_index) < MAX_ROWS);
  assign col_ok = ((CNT_W)'(in_data.col_index) < col_count_r)
                  && (32'(in_data.col_index) < MAX_COLS);

  always_comb begin
    unique case (in_data.op)
      OP_LOAD:  item_ok = col_ok;
      OP_MAC:   item_ok = row_ok && col_ok;
      OP_CLEAR: item_ok = 1'b1;
      OP_READ:  item_ok = row_ok;
      default:  item_ok = 1'b0;
    endcase
  end

  assign in_ready = issue_ready;
  assign accept   = in_valid && in_ready;

  assign iss.vld   = accept;
  assign iss.op    = in_data.op;
  assign iss.ok    = item_ok;
  assign iss.value = in_data.value;

  smvm_vec_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_vec_mem (
    .clk   (clk),
    .en    (accept),
    .we    (accept && (in_data.op == OP_LOAD) && col_ok),
    .addr  (COL_AW'(in_data.col_index)),
    .wdata (in_data.value),
    .rdata (vec_rd)
  );

  smvm_acc_engine #(
    .MAX_ROWS (MAX_ROWS)
  ) u_acc_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .iss         (iss),
    .iss_row     (ROW_AW'(in_data.row_index)),
    .vec_rd      (vec_rd),
    .issue_ready (issue_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> sv/smvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_checker
// Port-level checks on the sparse matrix-vector multiply.
// ----------------------------------------------------------------------------
module smvm_checker import smvm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input smvm_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input smvm_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a result with an error status carries a zero sum
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.sum == '0)
    else $error("nonzero sum with error status");

  // reset starts the clearing sweep
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during reset sweep");

  // a clear blocks the next request
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_CLEAR) |=> !in_ready)
    else $error("request taken behind a clear");

endmodule

bind sparse_matrix_vector_multiply smvm_checker u_smvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse matrix-vector multiply. A driver streams
// vector loads, nonzero multiply-accumulates, clears and reads. Its predictor
// tracks the vector and the row accumulators and checks every result in
// order. The row and column counts change between phases over their extremes.
// ----------------------------------------------------------------------------
module testbench;
  import smvm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int QUIET_FIRST = 500;
  localparam int QUIET_LAST  = 650;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  smvm_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  smvm_out_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sparse_matrix_vector_multiply u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  smvm_in_t  pending_reqs[$];
  smvm_out_t expected_results[$];
  int        err_cnt = 0;
  int        accept_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  // predictor copy of the block state
  logic [CNT_W-1:0]        rows_in_use = CNT_RESET;
  logic [CNT_W-1:0]        cols_in_use = CNT_RESET;
  logic signed [VAL_W-1:0] vec_mem [DEF_MAX_COLS];
  logic signed [ACC_W-1:0] acc_mem [DEF_MAX_ROWS];

  // stimulus-side view: which vector entries hold data, effective counts
  bit gen_written [DEF_MAX_COLS];
  int loaded_cols[$];
  int rows_eff = DEF_MAX_ROWS;
  int cols_eff = DEF_MAX_COLS;
  int hot_rows [8];

  initial begin
    foreach (acc_mem[i]) acc_mem[i] = '0;
    foreach (vec_mem[i]) vec_mem[i] = '0;
  end

  task automatic report(input string what);
    $display("mismatch @%0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  function automatic smvm_out_t predict_sum_status(smvm_in_t req);
    smvm_out_t res;
    longint    prod;
    longint    term;
    longint    total;
    bit        row_ok;
    bit        col_ok;
    res = '0;
    res.status = ST_OK;
    row_ok = (req.row_index < rows_in_use) && (req.row_index < DEF_MAX_ROWS);
    col_ok = (req.col_index < cols_in_use) && (req.col_index < DEF_MAX_COLS);
    case (req.op)
      OP_LOAD: begin
        if (col_ok) vec_mem[req.col_index] = req.value;
        else res.status = ST_RANGE;
      end
      OP_MAC: begin
        if (row_ok && col_ok) begin
          prod = longint'($signed(req.value)) * longint'($signed(vec_mem[req.col_index]));
          term = (prod + 64'sd32768) >>> 16;
          total = longint'($signed(acc_mem[req.row_index])) + term;
          if (total > longint'(ACC_MAX)) begin
            total = longint'(ACC_MAX);
            res.status = ST_SAT;
          end else if (total < longint'(ACC_MIN)) begin
            total = longint'(ACC_MIN);
            res.status = ST_SAT;
          end
          acc_mem[req.row_index] = total[ACC_W-1:0];
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_CLEAR: begin
        foreach (acc_mem[i]) acc_mem[i] = '0;
      end
      default: begin
        if (row_ok) res.sum = acc_mem[req.row_index];
        else res.status = ST_RANGE;
      end
    endcase
    return res;
  endfunction

  function automatic bit idle_draw();
    if (accept_cnt >= QUIET_FIRST && accept_cnt < QUIET_LAST) return 1'b0;
    return $urandom_range(99, 0) < 15;
  endfunction

  // driver: present pending requests, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_sum_status(in_data));
        accept_cnt <= accept_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (hold_left > 0 || !idle_draw())) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline backs up into in_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accept_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    smvm_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result sum=%0d status=%0d",
                           out_data.sum, out_data.status));
        end else begin
          want = expected_results.pop_front();
          if (out_data.sum !== want.sum)
            report($sformatf("sum got %0d want %0d", out_data.sum, want.sum));
          if (out_data.status !== want.status)
            report($sformatf("status got %0d want %0d", out_data.status, want.status));
        end
      end
      out_ready <= (hold_left == 0) && !idle_draw();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_below(int n);
    if (n == 0) return $urandom_range(DEF_MAX_ROWS - 1, 0);
    return $urandom_range(n - 1, 0);
  endfunction

  function automatic void mark_loaded(int col);
    if (!gen_written[col]) begin
      gen_written[col] = 1'b1;
      loaded_cols.push_back(col);
    end
  endfunction

  task automatic push_req(input logic [1:0] op, input int row, input int col,
                          input logic [VAL_W-1:0] val);
    smvm_in_t req;
    req.op        = op;
    req.row_index = row[IDX_W-1:0];
    req.col_index = col[IDX_W-1:0];
    req.value     = val;
    if (op == OP_LOAD && col < cols_eff) mark_loaded(col);
    pending_reqs.push_back(req);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_counts(input int rows_raw, input int cols_raw);
    logic [APB_DW-1:0] rv;
    logic [APB_DW-1:0] cv;
    rv = {(APB_DW-CNT_W)'($urandom_range(2097151, 0)), rows_raw[CNT_W-1:0]};
    cv = {(APB_DW-CNT_W)'($urandom_range(2097151, 0)), cols_raw[CNT_W-1:0]};
    apb_access(1'b1, REG_ROW_COUNT, rv);
    rows_in_use = rv[CNT_W-1:0];
    apb_access(1'b1, REG_COL_COUNT, cv);
    cols_in_use = cv[CNT_W-1:0];
    apb_access(1'b0, REG_ROW_COUNT, '0);
    if (prdata !== APB_DW'(rows_in_use))
      report($sformatf("row_count read %0h want %0h", prdata, rows_in_use));
    apb_access(1'b0, REG_COL_COUNT, '0);
    if (prdata !== APB_DW'(cols_in_use))
      report($sformatf("col_count read %0h want %0h", prdata, cols_in_use));
    rows_eff = (rows_in_use > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_in_use;
    cols_eff = (cols_in_use > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_in_use;
  endtask

  task automatic gen_random(input int n);
    smvm_in_t req;
    int       roll;
    int       tries;
    int       pick;
    bit       found;
    foreach (hot_rows[k]) hot_rows[k] = pick_below(rows_eff);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99, 0);
      req.row_index = IDX_W'($urandom);
      req.col_index = IDX_W'($urandom);
      case ($urandom_range(9, 0))
        0:       req.value = 32'h8000_0000;
        1:       req.value = 32'h7FFF_FFFF;
        2:       req.value = 32'hFFFF_FFFF;
        3:       req.value = 32'h0001_0000;
        default: req.value = $urandom;
      endcase
      if (roll < 25) begin
        req.op = OP_LOAD;
        if (cols_eff > 0 && $urandom_range(9, 0) < 8)
          req.col_index = IDX_W'(pick_below(cols_eff));
      end else if (roll < 80) begin
        req.op = OP_MAC;
        found = 1'b0;
        pick = 0;
        for (tries = 0; tries < 8 && !found && loaded_cols.size() > 0; tries++) begin
          pick = loaded_cols[$urandom_range(loaded_cols.size() - 1, 0)];
          found = pick < cols_eff;
        end
        if (found && rows_eff > 0 && $urandom_range(99, 0) < 85) begin
          req.col_index = IDX_W'(pick);
          req.row_index = IDX_W'(($urandom_range(1, 0) == 0) ? hot_rows[$urandom_range(7, 0)]
                                                             : pick_below(rows_eff));
        end
        // never multiply by a vector entry that holds no data: load it instead
        if (req.col_index < cols_eff && !gen_written[req.col_index]) req.op = OP_LOAD;
      end else if (roll < 82) begin
        req.op = OP_CLEAR;
      end else begin
        req.op = OP_READ;
        case ($urandom_range(4, 0))
          0, 1:    req.row_index = IDX_W'(hot_rows[$urandom_range(7, 0)]);
          2, 3:    req.row_index = IDX_W'(pick_below(rows_eff));
          default: req.row_index = IDX_W'($urandom);
        endcase
      end
      if (req.op == OP_LOAD && req.col_index < cols_eff) mark_loaded(int'(req.col_index));
      pending_reqs.push_back(req);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, rounding, saturation both ways, repeated rows, clear
    push_req(OP_READ,  0,    0,    32'h0);
    push_req(OP_LOAD,  0,    0,    32'h8000_0000);
    push_req(OP_LOAD,  0,    1023, 32'h7FFF_FFFF);
    push_req(OP_LOAD,  0,    1,    32'h0001_0000);
    push_req(OP_LOAD,  0,    2,    32'h0000_8000);
    push_req(OP_MAC,   0,    0,    32'h8000_0000);
    push_req(OP_MAC,   0,    0,    32'h8000_0000);
    push_req(OP_READ,  0,    0,    32'h0);
    push_req(OP_MAC,   1023, 1023, 32'h8000_0000);
    push_req(OP_MAC,   1023, 1023, 32'h8000_0000);
    push_req(OP_MAC,   1023, 1023, 32'h8000_0000);
    push_req(OP_READ,  1023, 0,    32'h0);
    push_req(OP_MAC,   6,    2,    32'h0000_0001);
    push_req(OP_MAC,   6,    2,    32'hFFFF_FFFF);
    push_req(OP_READ,  6,    0,    32'h0);
    push_req(OP_MAC,   5,    1,    32'hFFFF_FFFF);
    push_req(OP_MAC,   5,    1,    32'h7FFF_FFFF);
    push_req(OP_MAC,   5,    1,    32'h8000_0000);
    push_req(OP_READ,  5,    0,    32'h0);
    push_req(OP_CLEAR, 0,    0,    32'h0);
    push_req(OP_READ,  0,    0,    32'h0);
    push_req(OP_READ,  1023, 0,    32'h0);
    gen_random(220);
    wait_drained();

    set_counts(2047, 2047);
    gen_random(160);
    wait_drained();

    set_counts(1, 1);
    gen_random(100);
    wait_drained();

    set_counts(0, 0);
    gen_random(60);
    wait_drained();

    set_counts($urandom_range(1024, 1), $urandom_range(1024, 1));
    gen_random(200);
    wait_drained();

    set_counts(1024, $urandom_range(2047, 1));
    gen_random(160);
    wait_drained();

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/smvm_pkg.sv
sv/smvm_vec_mem.sv
sv/smvm_acc_engine.sv
sv/sparse_matrix_vector_multiply.sv
sv/smvm_checker.sv
tb/sv/testbench.sv
